// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int USES_BITS      = 32;
    localparam int CAP_BITS       = 5;
    localparam int PORT_BITS      = 32;

    localparam logic [1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic hit;
        logic evicted;
    } lfu_flags_t;

endpackage

// ===== sv/lfu_stream_if.sv =====
interface lfu_stream_if #(
    parameter int PAYLOAD_BITS = 1
);
    logic                    valid;
    logic                    ready;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/lfu_cache_lru_tiebreak.sv =====
// Channel   Dir   Payload (msb..lsb)
// req       in    action, lookup_key, write_value
// rsp       out   hit, read_value, evicted, evicted_key
// apb       in    capacity at byte address 0
//
// An item that updates the cache makes two passes: a scan over the slot memory finds key
// and victim, a second pass rewrites ranks. A get miss or a put at zero capacity skips
// the rank pass. Any wait on rsp holds the result beat until it is taken.
// Both passes share one read port of the slot memory, one slot a cycle.
// rst_n clears valid bits, fill count and capacity (16) at once; no clear pass.
// req is not ready from acceptance until the result beat is taken.
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lfu_stream_if.sink                    req,
    lfu_stream_if.source                  rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [lfu_pkg::PORT_BITS-1:0] pwdata,
    output logic [lfu_pkg::PORT_BITS-1:0] prdata,
    output logic                          pready
);
    logic [lfu_pkg::CAP_BITS-1:0] capacity;
    lfu_pkg::lfu_flags_t          flags;
    logic [VALUE_BITS-1:0]        read_value;
    logic [KEY_BITS-1:0]          evicted_key;

    lfu_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .capacity(capacity)
    );

    lfu_core #(
        .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_core (
        .clk(clk), .rst_n(rst_n), .capacity(capacity),
        .in_valid(req.valid), .in_ready(req.ready),
        .in_action(req.payload[KEY_BITS+VALUE_BITS]),
        .in_key(req.payload[KEY_BITS+VALUE_BITS-1:VALUE_BITS]),
        .in_value(req.payload[VALUE_BITS-1:0]),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .out_flags(flags), .out_read_value(read_value),
        .out_evicted_key(evicted_key)
    );

    // pack the result beat
    assign rsp.payload = {flags.hit, read_value, flags.evicted, evicted_key};
endmodule

// ===== sv/lfu_cfg.sv =====
module lfu_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [lfu_pkg::PORT_BITS-1:0] pwdata,
    output logic [lfu_pkg::PORT_BITS-1:0] prdata,
    output logic                          pready,
    output logic [lfu_pkg::CAP_BITS-1:0]  capacity
);
    logic [lfu_pkg::CAP_BITS-1:0] cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && paddr == lfu_pkg::ADDR_CAPACITY)
        begin
            cap_reg <= pwdata[lfu_pkg::CAP_BITS-1:0];
        end
    end

    assign pready   = 1'b1;
    assign capacity = cap_reg;
    assign prdata   = (paddr == lfu_pkg::ADDR_CAPACITY)
                    ? {{(lfu_pkg::PORT_BITS-lfu_pkg::CAP_BITS){1'b0}}, cap_reg}
                    : '0;
endmodule

// ===== sv/lfu_core.sv =====
module lfu_core #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lfu_pkg::CAP_BITS-1:0] capacity,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_action,
    input  logic [KEY_BITS-1:0]          in_key,
    input  logic [VALUE_BITS-1:0]        in_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lfu_pkg::lfu_flags_t          out_flags,
    output logic [VALUE_BITS-1:0]        out_read_value,
    output logic [KEY_BITS-1:0]          out_evicted_key
);
    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int RANK_BITS = IDX_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RANK, S_WRITE, S_OUT
    } state_t;

    // slot memories, one read port each, registered read
    logic [KEY_BITS-1:0]          key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0]        value_mem [ENTRIES];
    logic [lfu_pkg::USES_BITS-1:0] uses_mem [ENTRIES];
    logic [RANK_BITS-1:0]         rank_mem  [ENTRIES];
    logic [ENTRIES-1:0]           valid_reg, valid_next;

    state_t                       state_reg, state_next;
    logic [CNT_BITS-1:0]          idx_reg, idx_next;
    logic [IDX_BITS-1:0]          rd_idx_reg, rd_idx_next;
    logic [KEY_BITS-1:0]          rd_key_reg;
    logic [VALUE_BITS-1:0]        rd_val_reg;
    logic [lfu_pkg::USES_BITS-1:0] rd_uses_reg;
    logic [RANK_BITS-1:0]         rd_rank_reg;
    logic [CNT_BITS-1:0]          fill_reg, fill_next;

    logic                         act_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [VALUE_BITS-1:0]        val_reg;
    logic                         found_reg, found_next;
    logic [IDX_BITS-1:0]          fidx_reg, fidx_next;
    logic [RANK_BITS-1:0]         frank_reg, frank_next;
    logic                         vic_reg, vic_next;
    logic [IDX_BITS-1:0]          vidx_reg, vidx_next;
    logic [lfu_pkg::USES_BITS-1:0] vuses_reg, vuses_next;
    logic [RANK_BITS-1:0]         vrank_reg, vrank_next;
    logic [KEY_BITS-1:0]          vkey_reg, vkey_next;
    logic                         free_ok_reg, free_ok_next;
    logic [IDX_BITS-1:0]          free_reg, free_next;
    // update plan: mode 0 = touch, 1 = insert
    logic                         ins_reg, ins_next;
    logic [IDX_BITS-1:0]          tgt_reg, tgt_next;
    logic                         flag_hit_reg, flag_hit_next;
    logic                         flag_ev_reg, flag_ev_next;
    logic [VALUE_BITS-1:0]        rv_reg, rv_next;
    logic [KEY_BITS-1:0]          ek_reg, ek_next;

    logic [CNT_BITS-1:0]          cap_eff;
    logic                         rank_we;
    logic [RANK_BITS-1:0]         rank_wd;
    logic                         slot_we;
    logic                         uses_we;
    logic [lfu_pkg::USES_BITS-1:0] uses_wd;
    logic                         val_we;
    logic                         last_idx;

    assign cap_eff = (int'(capacity) > ENTRIES)
                   ? CNT_BITS'(ENTRIES) : CNT_BITS'(capacity);
    assign last_idx = (idx_reg == CNT_BITS'(ENTRIES - 1));
    assign rd_idx_next = idx_next[IDX_BITS-1:0];

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        fill_next    = fill_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        frank_next   = frank_reg;
        vic_next     = vic_reg;
        vidx_next    = vidx_reg;
        vuses_next   = vuses_reg;
        vrank_next   = vrank_reg;
        vkey_next    = vkey_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        ins_next     = ins_reg;
        tgt_next     = tgt_reg;
        flag_hit_next = flag_hit_reg;
        flag_ev_next  = flag_ev_reg;
        rv_next      = rv_reg;
        ek_next      = ek_reg;
        rank_we      = 1'b0;
        rank_wd      = rd_rank_reg;
        slot_we      = 1'b0;
        uses_we      = 1'b0;
        uses_wd      = rd_uses_reg;
        val_we       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = S_SCAN;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    vic_next     = 1'b0;
                    free_ok_next = 1'b0;
                    flag_hit_next = 1'b0;
                    flag_ev_next  = 1'b0;
                    rv_next      = '0;
                    ek_next      = '0;
                end
            end
            S_SCAN:
            begin
                // compare one slot per cycle against key and victim
                if (valid_reg[rd_idx_reg])
                begin
                    if (!found_reg && rd_key_reg == key_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = rd_idx_reg;
                        frank_next = rd_rank_reg;
                        rv_next    = rd_val_reg;
                    end
                    if (!vic_reg || rd_uses_reg < vuses_reg ||
                        (rd_uses_reg == vuses_reg && rd_rank_reg > vrank_reg))
                    begin
                        vic_next   = 1'b1;
                        vidx_next  = rd_idx_reg;
                        vuses_next = rd_uses_reg;
                        vrank_next = rd_rank_reg;
                        vkey_next  = rd_key_reg;
                    end
                end
                else if (!free_ok_reg)
                begin
                    free_ok_next = 1'b1;
                    free_next    = rd_idx_reg;
                end
                if (last_idx)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                idx_next   = '0;
                if (!act_reg)
                begin
                    flag_hit_next = found_reg;
                    if (!found_reg)
                    begin
                        rv_next = '0;
                    end
                    else
                    begin
                        ins_next   = 1'b0;
                        tgt_next   = fidx_reg;
                        state_next = S_RANK;
                    end
                end
                else
                begin
                    rv_next = '0;
                    if (cap_eff == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else if (found_reg)
                    begin
                        flag_hit_next = 1'b1;
                        ins_next   = 1'b0;
                        tgt_next   = fidx_reg;
                        state_next = S_RANK;
                    end
                    else if (fill_reg >= cap_eff && vic_reg)
                    begin
                        // evict: victim slot becomes the new entry
                        flag_ev_next = 1'b1;
                        ek_next      = vkey_reg;
                        frank_next   = vrank_reg;
                        valid_next[vidx_reg] = 1'b0;
                        fill_next    = fill_reg - 1'b1;
                        ins_next     = 1'b1;
                        tgt_next     = vidx_reg;
                        state_next   = S_RANK;
                    end
                    else if (free_ok_reg)
                    begin
                        // no victim: rank raises every valid entry by one
                        frank_next = {RANK_BITS{1'b1}};
                        ins_next   = 1'b1;
                        tgt_next   = free_reg;
                        state_next = S_RANK;
                    end
                end
            end
            S_RANK:
            begin
                // age every valid entry younger than the reference rank;
                // on insert after eviction, older entries keep their rank
                if (valid_reg[rd_idx_reg] && rd_idx_reg != tgt_reg)
                begin
                    if (ins_reg)
                    begin
                        if (flag_ev_reg ? (rd_rank_reg < frank_reg) : 1'b1)
                        begin
                            rank_we = 1'b1;
                            rank_wd = rd_rank_reg + 1'b1;
                        end
                    end
                    else if (rd_rank_reg < frank_reg)
                    begin
                        rank_we = 1'b1;
                        rank_wd = rd_rank_reg + 1'b1;
                    end
                end
                if (last_idx)
                begin
                    state_next = S_WRITE;
                    idx_next   = CNT_BITS'(tgt_reg);
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                rank_we = 1'b1;
                rank_wd = '0;
                uses_we = 1'b1;
                if (ins_reg)
                begin
                    slot_we = 1'b1;
                    val_we  = 1'b1;
                    uses_wd = lfu_pkg::USES_BITS'(1);
                    valid_next[tgt_reg] = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    val_we  = act_reg;
                    uses_wd = (&rd_uses_reg) ? rd_uses_reg : rd_uses_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            act_reg <= in_action;
            key_reg <= in_key;
            val_reg <= in_value;
        end
        rd_idx_reg   <= rd_idx_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        frank_reg    <= frank_next;
        vic_reg      <= vic_next;
        vidx_reg     <= vidx_next;
        vuses_reg    <= vuses_next;
        vrank_reg    <= vrank_next;
        vkey_reg     <= vkey_next;
        free_ok_reg  <= free_ok_next;
        free_reg     <= free_next;
        ins_reg      <= ins_next;
        tgt_reg      <= tgt_next;
        flag_hit_reg <= flag_hit_next;
        flag_ev_reg  <= flag_ev_next;
        rv_reg       <= rv_next;
        ek_reg       <= ek_next;
    end

    // memory ports: read at rd_idx_next, write at the current index
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[rd_idx_next];
        rd_val_reg  <= value_mem[rd_idx_next];
        rd_uses_reg <= uses_mem[rd_idx_next];
        rd_rank_reg <= rank_mem[rd_idx_next];
        if (rank_we)
        begin
            rank_mem[rd_idx_reg] <= rank_wd;
        end
        if (slot_we)
        begin
            key_mem[rd_idx_reg] <= key_reg;
        end
        if (val_we)
        begin
            value_mem[rd_idx_reg] <= val_reg;
        end
        if (uses_we)
        begin
            uses_mem[rd_idx_reg] <= uses_wd;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign out_flags.hit   = flag_hit_reg;
    assign out_flags.evicted = flag_ev_reg;
    assign out_read_value  = rv_reg;
    assign out_evicted_key = ek_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_BITS'(ENTRIES))
        else $error("fill count above entries");
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (CNT_BITS'($countones(valid_reg)) == fill_reg))
        else $error("fill count differs from valid slots");
    a_ev_put: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_flags.evicted |-> act_reg && !out_flags.hit)
        else $error("eviction on get or hit");
    a_read_get: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && act_reg |-> out_read_value == '0)
        else $error("read value on put");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(valid_reg) || (state_reg == S_DECIDE))
        else $error("valid bits change during scan");
`endif
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS       = lfu_pkg::ENTRIES_DEF;
    localparam int DRAIN_WAIT  = 2 * SLOTS + 8;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 210;
    localparam int KEY_POOL    = 20;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] lookup_key;
        logic [31:0] write_value;
    } req_beat_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } rsp_beat_t;

    // One directed row: the access plus, where known by inspection, its result.
    typedef struct {
        req_beat_t acc;
        bit        known;
        rsp_beat_t res;
    } access_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [lfu_pkg::PORT_BITS-1:0] pwdata;
    logic [lfu_pkg::PORT_BITS-1:0] prdata;
    logic pready;

    lfu_stream_if #(.PAYLOAD_BITS($bits(req_beat_t))) req ();
    lfu_stream_if #(.PAYLOAD_BITS($bits(rsp_beat_t))) rsp ();

    lfu_cache_lru_tiebreak u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the cache contents and its capacity register.
    logic              cache_valid [SLOTS];
    logic [31:0]       cache_key   [SLOTS];
    logic [31:0]       cache_value [SLOTS];
    logic [31:0]       cache_uses  [SLOTS];
    logic [3:0]        cache_age   [SLOTS];
    int                cache_fill;
    logic [lfu_pkg::CAP_BITS-1:0] cache_cap;

    rsp_beat_t   pending_rsp[$];
    logic [31:0] key_pool [KEY_POOL];
    int          fail_count;
    int          idle_cycles;
    int          src_idle_pct;
    int          snk_idle_pct;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Make slot s the most recent and count one more use, saturating.
    function automatic void touch_slot(input int s);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cache_valid[i] && cache_age[i] < cache_age[s])
                cache_age[i]++;
        end
        cache_age[s] = '0;
        if (cache_uses[s] != '1)
            cache_uses[s]++;
    endfunction

    // Apply one access to the shadow cache and return the beat it must produce.
    function automatic rsp_beat_t cache_access(input req_beat_t a);
        rsp_beat_t r;
        int        found;
        int        slot;
        int        eff_cap;
        logic [3:0] gone_age;
        r       = '0;
        found   = -1;
        slot    = -1;
        eff_cap = (cache_cap > SLOTS) ? SLOTS : int'(cache_cap);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (found < 0 && cache_valid[i] && cache_key[i] == a.lookup_key)
                found = i;
        end
        if (a.action == OP_GET)
        begin
            if (found >= 0)
            begin
                r.hit        = 1'b1;
                r.read_value = cache_value[found];
                touch_slot(found);
            end
            return r;
        end
        // A put with zero capacity leaves everything alone, even on a hit.
        if (eff_cap == 0)
            return r;
        if (found >= 0)
        begin
            r.hit              = 1'b1;
            cache_value[found] = a.write_value;
            touch_slot(found);
            return r;
        end
        if (cache_fill >= eff_cap)
        begin
            // Victim: fewest uses, oldest on a tie.
            for (int i = 0; i < SLOTS; i++)
            begin
                if (cache_valid[i] && (slot < 0 || cache_uses[i] < cache_uses[slot] ||
                    (cache_uses[i] == cache_uses[slot] && cache_age[i] > cache_age[slot])))
                    slot = i;
            end
            if (slot >= 0)
            begin
                gone_age          = cache_age[slot];
                r.evicted         = 1'b1;
                r.evicted_key     = cache_key[slot];
                cache_valid[slot] = 1'b0;
                cache_fill--;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (cache_valid[i] && cache_age[i] > gone_age)
                        cache_age[i]--;
                end
            end
        end
        if (slot < 0)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!cache_valid[i])
                    slot = i;
            end
            if (slot < 0)
                return r;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cache_valid[i])
                cache_age[i]++;
        end
        cache_valid[slot] = 1'b1;
        cache_key[slot]   = a.lookup_key;
        cache_value[slot] = a.write_value;
        cache_uses[slot]  = 32'd1;
        cache_age[slot]   = '0;
        cache_fill++;
        return r;
    endfunction

    // Drive one access beat, hold it until taken, then log what must come back.
    task automatic send_access(input req_beat_t a, input bit known, input rsp_beat_t res);
        rsp_beat_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.payload <= a;
        do
            @(posedge clk);
        while (!req.ready);
        predicted = cache_access(a);
        pending_rsp.push_back(known ? res : predicted);
    endtask

    // Hold the sender until every outstanding result is back, plus the pipeline.
    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Two-phase APB write of the capacity register; the cache is idle here.
    task automatic write_capacity(input logic [lfu_pkg::CAP_BITS-1:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lfu_pkg::ADDR_CAPACITY;
        pwdata  <= lfu_pkg::PORT_BITS'(cap);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cache_cap = cap;
    endtask

    function automatic req_beat_t random_access();
        req_beat_t a;
        a.action      = 1'($urandom_range(1));
        a.lookup_key  = ($urandom_range(99) < 75) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                                  : $urandom;
        a.write_value = $urandom;
        return a;
    endfunction

    // Receiver: stall at the rate of the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare each result beat against the oldest outstanding one.
    always @(posedge clk)
    begin
        rsp_beat_t got;
        rsp_beat_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = rsp.payload;
            if (pending_rsp.size() == 0)
            begin
                $error("result beat with nothing outstanding: %h", got);
                fail_count++;
            end
            else
            begin
                want = pending_rsp[0];
                pending_rsp.delete(0);
                if (got.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    fail_count++;
                end
                if (got.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                    fail_count++;
                end
                if (got.evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                    fail_count++;
                end
                if (got.evicted_key !== want.evicted_key)
                begin
                    $error("evicted_key: expected %h, got %h", want.evicted_key,
                           got.evicted_key);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        access_row_t        rows[$];
        logic [lfu_pkg::CAP_BITS-1:0] caps[] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd8,
                                                 5'd2, 5'd5, 5'd16};
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req.valid    = 1'b0;
        req.payload  = '0;
        fail_count   = 0;
        idle_cycles  = 0;
        src_idle_pct = 30;
        snk_idle_pct = 55;
        cache_fill   = 0;
        cache_cap    = lfu_pkg::CAP_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_uses[i]  = '0;
            cache_age[i]   = '0;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        // Directed: extremes first with results read off directly, then
        // eviction order and tie-break, all predicted. Capacity above the slot
        // count, zero capacity and capacity dropped under the fill come in the random phases.
        rows.push_back('{'{OP_GET, 32'h0, 32'h0}, 1, '{1'b0, 32'h0, 1'b0, 32'h0}});
        rows.push_back('{'{OP_PUT, 32'h0, 32'hFFFF_FFFF}, 1, '{1'b0, 32'h0, 1'b0, 32'h0}});
        rows.push_back('{'{OP_GET, 32'h0, 32'h0}, 1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}});
        rows.push_back('{'{OP_PUT, 32'hFFFF_FFFF, 32'h0}, 1, '{1'b0, 32'h0, 1'b0, 32'h0}});
        rows.push_back('{'{OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
                         '{1'b1, 32'h0, 1'b0, 32'h0}});
        rows.push_back('{'{OP_PUT, 32'h0, 32'h1234_5678}, 1, '{1'b1, 32'h0, 1'b0, 32'h0}});
        rows.push_back('{'{OP_GET, 32'h0, 32'h0}, 1, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}});
        rows.push_back('{'{OP_GET, 32'hA5A5_5A5A, 32'h0}, 1, '{1'b0, 32'h0, 1'b0, 32'h0}});
        for (int i = 0; i < 16; i++)
            rows.push_back('{'{OP_PUT, 32'h100 + i, $urandom}, 0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_access(rows[i].acc, rows[i].known, rows[i].res);

        // Random phases, each under its own capacity. Idling: receiver-heavy,
        // then sender-heavy, then none at all.
        foreach (caps[p])
        begin
            drain_results();
            write_capacity(caps[p]);
            src_idle_pct = (p < 3) ? 30 : (p < 6) ? 55 : 0;
            snk_idle_pct = (p < 3) ? 55 : (p < 6) ? 30 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_access(random_access(), 0, '0);
        end

        drain_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
